@@ rtl/rgm_pkg.sv @@
`timescale 1ns / 1ps

package rgm_pkg;

    // Field widths
    localparam int CHAN_W  = 8;
    localparam int GRAY_W  = 16;
    localparam int MEAN_W  = 16;
    localparam int ROW_W   = 10;
    localparam int OCOL_W  = 7;
    localparam int FW_W    = 8;
    localparam int FH_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Line memory word: middle row in the upper half, upper row in the lower half
    localparam int LINE_W = 2 * GRAY_W;

    // Window sums: one column of three grays, then all nine
    localparam int COLSUM_W = GRAY_W + 2;
    localparam int PAIR_W   = GRAY_W + 3;
    localparam int SUM_W    = GRAY_W + 4;

    localparam int MAX_WIDTH_DEFAULT = 128;
    localparam int MAX_HEIGHT        = 1024;
    localparam int OUT_FIFO_DEPTH    = 8;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 8'd128;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 11'd128;
    localparam logic [FW_W-1:0] FRAME_WIDTH_MIN    = 8'd3;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN   = 11'd3;

    // BT.601 luma weights scaled by 256
    localparam logic [7:0] GRAY_R_WEIGHT = 8'd77;
    localparam logic [7:0] GRAY_G_WEIGHT = 8'd150;
    localparam logic [7:0] GRAY_B_WEIGHT = 8'd29;

    // floor(n / 9) == (n * ceil(2^23 / 9)) >> 23 for all n < 2^20
    localparam int               RECIP_SHIFT = 23;
    localparam logic [SUM_W-1:0] RECIP_MUL   = 20'd932068;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } rgm_reg_index_t;

    // Position and flag carried with each window
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } rgm_tag_t;

    // Pixel info handed from the accept stage to the window stage
    typedef struct packed {
        logic     emit;
        rgm_tag_t tag;
    } rgm_pix_t;

endpackage

@@ rtl/rgm_line_mem.sv @@
`timescale 1ns / 1ps

module rgm_line_mem
    import rgm_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/rgm_window.sv @@
`timescale 1ns / 1ps

module rgm_window
    import rgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    // accepted pixel
    input  logic              pix_valid,
    input  logic [GRAY_W-1:0] pix_gray,
    input  logic [ADDR_W-1:0] pix_addr,
    input  rgm_pix_t          pix_info,
    // line memory
    input  logic [LINE_W-1:0] mem_rd_data,
    output logic              wb_en,
    output logic [ADDR_W-1:0] wb_addr,
    output logic [LINE_W-1:0] wb_data,
    // results
    output logic              push,
    output logic [MEAN_W-1:0] push_mean,
    output rgm_tag_t          push_tag,
    output logic [1:0]        pending
);

    // stage 1: line memory data arrives
    logic              s1_valid_reg;
    logic [GRAY_W-1:0] s1_gray_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    rgm_pix_t          s1_info_reg;

    // column sums of the two previous window columns
    logic [COLSUM_W-1:0] cs1_reg;
    logic [COLSUM_W-1:0] cs2_reg;

    // stage 2: current column sum and sum of the two older ones
    logic                s2_valid_reg;
    logic [COLSUM_W-1:0] s2_colsum_reg;
    logic [PAIR_W-1:0]   s2_pair_reg;
    rgm_tag_t            s2_tag_reg;

    // stage 3: nine-value sum
    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_total_reg;
    rgm_tag_t         s3_tag_reg;

    logic [GRAY_W-1:0]     up;
    logic [GRAY_W-1:0]     mid;
    logic [COLSUM_W-1:0]   colsum;
    logic [PAIR_W-1:0]     pair;
    logic [2*SUM_W-1:0]    product;

    assign up     = mem_rd_data[GRAY_W-1:0];
    assign mid    = mem_rd_data[LINE_W-1:GRAY_W];
    assign colsum = COLSUM_W'(up) + COLSUM_W'(mid) + COLSUM_W'(s1_gray_reg);
    assign pair   = PAIR_W'(cs1_reg) + PAIR_W'(cs2_reg);

    // shift the rows down by one at this column
    assign wb_en   = s1_valid_reg;
    assign wb_addr = s1_addr_reg;
    assign wb_data = {s1_gray_reg, mid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cs1_reg      <= '0;
            cs2_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= pix_valid;
            s2_valid_reg <= s1_valid_reg && s1_info_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                cs2_reg <= cs1_reg;
                cs1_reg <= colsum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid)
        begin
            s1_gray_reg <= pix_gray;
            s1_addr_reg <= pix_addr;
            s1_info_reg <= pix_info;
        end
        if (s1_valid_reg)
        begin
            s2_colsum_reg <= colsum;
            s2_pair_reg   <= pair;
            s2_tag_reg    <= s1_info_reg.tag;
        end
        if (s2_valid_reg)
        begin
            s3_total_reg <= SUM_W'(s2_colsum_reg) + SUM_W'(s2_pair_reg);
            s3_tag_reg   <= s2_tag_reg;
        end
    end

    // divide by nine through the reciprocal; the FIFO registers the quotient
    assign product   = (2*SUM_W)'(s3_total_reg) * (2*SUM_W)'(RECIP_MUL);
    assign push      = s3_valid_reg;
    assign push_mean = product[RECIP_SHIFT +: MEAN_W];
    assign push_tag  = s3_tag_reg;

    assign pending = 2'(s1_valid_reg && s1_info_reg.emit) + 2'(s2_valid_reg)
                   + 2'(s3_valid_reg);

endmodule

@@ rtl/rgm_out_fifo.sv @@
`timescale 1ns / 1ps

module rgm_out_fifo
    import rgm_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [MEAN_W-1:0] push_mean,
    input  rgm_tag_t          push_tag,
    input  logic              pop,
    output logic              not_empty,
    output logic [MEAN_W-1:0] head_mean,
    output rgm_tag_t          head_tag,
    output logic [CNT_W-1:0]  count
);

    logic [MEAN_W-1:0] mean_q [DEPTH];
    rgm_tag_t          tag_q  [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mean_q[wr_ptr_reg] <= push_mean;
            tag_q[wr_ptr_reg]  <= push_tag;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_mean = mean_q[rd_ptr_reg];
    assign head_tag  = tag_q[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ rtl/rgb_gray_mean3x3_filter_core.sv @@
`timescale 1ns / 1ps

// RGB to BT.601 gray (Q8.8) with a 3x3 box mean over a raster pixel stream.
// One pixel is taken per clock while pixel_ready is high. The pixel at
// (row, col), with row and col both at least 2, gives the result for the
// window centered at (row-1, col-1); pixels in rows or columns 0 and 1 give
// none. The rate is set by the line memory: each pixel does one read of its
// column and one write-back the next cycle, and consecutive pixels always
// touch different columns. An eight-entry output FIFO decouples the result
// side, so pixels keep flowing while results wait, until it could overrun.
// After reset the line memory is cleared one entry a cycle, pixel_ready low;
// configuration writes are taken at any time and should be made between frames.

module rgb_gray_mean3x3_filter_core
    import rgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // pixels
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  logic [CHAN_W-1:0]      red,
    input  logic [CHAN_W-1:0]      green,
    input  logic [CHAN_W-1:0]      blue,
    // results
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [MEAN_W-1:0]      mean_value,
    output logic [ROW_W-1:0]       center_row,
    output logic [OCOL_W-1:0]      center_col,
    output logic                   frame_last
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W > FW_W) ? COL_W : FW_W;
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             clearing_reg;
    logic [COL_W-1:0] clear_addr_reg;

    logic             accept;
    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [CMP_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic [CMP_W-1:0] col_ext;
    logic             col_wrap;
    logic             row_wrap;
    logic [GRAY_W-1:0] gray;
    rgm_pix_t         pix_info;

    logic              mem_rd_en;
    logic [LINE_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [COL_W-1:0]  mem_wr_addr;
    logic [LINE_W-1:0] mem_wr_data;
    logic              wb_en;
    logic [COL_W-1:0]  wb_addr;
    logic [LINE_W-1:0] wb_data;

    logic              push;
    logic [MEAN_W-1:0] push_mean;
    rgm_tag_t          push_tag;
    logic [1:0]        pending;
    logic [CNT_W-1:0]  fifo_count;
    logic [CNT_W:0]    occupancy;
    rgm_tag_t          head_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp the frame size to what the line memory and row counter support
    always_comb
    begin
        if (frame_width_reg < FRAME_WIDTH_MIN)
        begin
            w_eff = FRAME_WIDTH_MIN;
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end

        if (frame_height_reg < FRAME_HEIGHT_MIN)
        begin
            h_eff = FRAME_HEIGHT_MIN;
        end
        else if (frame_height_reg > FH_W'(MAX_HEIGHT))
        begin
            h_eff = FH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    assign w_last   = CMP_W'(w_eff) - 1'b1;
    assign h_last   = ROW_W'(h_eff - 1'b1);
    assign col_ext  = CMP_W'(col_reg);
    assign col_wrap = (col_ext >= w_last);
    assign row_wrap = (row_reg >= h_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    // hold off pixels while clearing or while results in flight could overrun the FIFO
    assign occupancy   = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(pending);
    assign pixel_ready = !clearing_reg && (occupancy < (CNT_W + 1)'(OUT_FIFO_DEPTH));
    assign accept      = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    assign gray = GRAY_W'(red) * GRAY_W'(GRAY_R_WEIGHT)
                + GRAY_W'(green) * GRAY_W'(GRAY_G_WEIGHT)
                + GRAY_W'(blue) * GRAY_W'(GRAY_B_WEIGHT);

    assign pix_info.emit     = (row_reg >= ROW_W'(2)) && (col_ext >= CMP_W'(2));
    assign pix_info.tag.row  = row_reg - 1'b1;
    assign pix_info.tag.col  = OCOL_W'(col_ext - 1'b1);
    assign pix_info.tag.last = row_wrap && col_wrap;

    assign mem_rd_en   = accept;
    assign mem_wr_en   = clearing_reg || wb_en;
    assign mem_wr_addr = clearing_reg ? clear_addr_reg : wb_addr;
    assign mem_wr_data = clearing_reg ? '0 : wb_data;

    rgm_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (col_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    rgm_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (accept),
        .pix_gray    (gray),
        .pix_addr    (col_reg),
        .pix_info    (pix_info),
        .mem_rd_data (mem_rd_data),
        .wb_en       (wb_en),
        .wb_addr     (wb_addr),
        .wb_data     (wb_data),
        .push        (push),
        .push_mean   (push_mean),
        .push_tag    (push_tag),
        .pending     (pending)
    );

    rgm_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_mean (push_mean),
        .push_tag  (push_tag),
        .pop       (result_ready),
        .not_empty (result_valid),
        .head_mean (mean_value),
        .head_tag  (head_tag),
        .count     (fifo_count)
    );

    assign center_row = head_tag.row;
    assign center_col = head_tag.col;
    assign frame_last = head_tag.last;

    // a pixel never reads the column that is being written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (col_reg != mem_wr_addr))
        else $error("line memory read and write hit the same column");

    // the credit check keeps the FIFO from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count < CNT_W'(OUT_FIFO_DEPTH)) || result_ready)
        else $error("output FIFO overflow");

    // no pixel enters while the line memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pixel_ready)
        else $error("pixel accepted during line memory clear");

    // a pixel that completes a window puts a result in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pix_info.emit) |=> (pending != 2'd0))
        else $error("window result lost after accept");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rgm_pkg::*;

    localparam int WINDOW_TAPS    = 9;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_SETTLE    = 8;
    localparam int END_SETTLE     = 20;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int FIXED_PHASES   = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [2:0] WRITE_COLS  = 3'b001;
    localparam logic [2:0] WRITE_ROWS  = 3'b010;
    localparam logic [2:0] WRITE_SPARE = 3'b100;

    typedef enum int {DRAIN_FREE, DRAIN_RANDOM, DRAIN_HOLD} drain_mode_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        rgm_tag_t          tag;
    } mean_result_t;

    class mean_scoreboard;
        logic [GRAY_W-1:0] upper_line [MAX_WIDTH_DEFAULT];
        logic [GRAY_W-1:0] middle_line [MAX_WIDTH_DEFAULT];
        logic [GRAY_W-1:0] window [6];
        logic [ROW_W-1:0]  row_pos;
        logic [OCOL_W-1:0] col_pos;
        logic [FW_W-1:0]   width_reg;
        logic [FH_W-1:0]   height_reg;
        mean_result_t      pending_means [$];
        int                mismatches;

        function new();
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            row_pos    = '0;
            col_pos    = '0;
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            mismatches = 0;
        endfunction

        function int unsigned frame_cols();
            int unsigned w;
            w = width_reg;
            if (w < FRAME_WIDTH_MIN)
                w = FRAME_WIDTH_MIN;
            if (w > MAX_WIDTH_DEFAULT)
                w = MAX_WIDTH_DEFAULT;
            return w;
        endfunction

        function int unsigned frame_rows();
            int unsigned h;
            h = height_reg;
            if (h < FRAME_HEIGHT_MIN)
                h = FRAME_HEIGHT_MIN;
            if (h > MAX_HEIGHT)
                h = MAX_HEIGHT;
            return h;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_FRAME_WIDTH)
                width_reg = data[FW_W-1:0];
            else if (index == REG_FRAME_HEIGHT)
                height_reg = data[FH_W-1:0];
        endfunction

        function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                 logic [CHAN_W-1:0] b);
            int unsigned       w;
            int unsigned       h;
            logic [GRAY_W-1:0] gray;
            logic [GRAY_W-1:0] up;
            logic [GRAY_W-1:0] mid;
            logic [SUM_W-1:0]  sum;
            mean_result_t      item;
            w    = frame_cols();
            h    = frame_rows();
            gray = GRAY_R_WEIGHT * r + GRAY_G_WEIGHT * g + GRAY_B_WEIGHT * b;
            up   = upper_line[col_pos];
            mid  = middle_line[col_pos];
            if (row_pos >= 2 && col_pos >= 2)
            begin
                sum = up + mid + gray;
                for (int k = 0; k < 6; k++)
                    sum += window[k];
                item.mean     = MEAN_W'(sum / WINDOW_TAPS);
                item.tag.row  = row_pos - 1'b1;
                item.tag.col  = col_pos - 1'b1;
                item.tag.last = (row_pos >= h - 1) && (col_pos >= w - 1);
                pending_means.push_back(item);
            end
            // shift the window one column left
            for (int k = 0; k < 3; k++)
                window[k] = window[k + 3];
            window[3] = up;
            window[4] = mid;
            window[5] = gray;
            upper_line[col_pos]  = mid;
            middle_line[col_pos] = gray;
            if (col_pos >= w - 1)
            begin
                col_pos = '0;
                if (row_pos >= h - 1)
                    row_pos = '0;
                else
                    row_pos++;
            end
            else
            begin
                col_pos++;
            end
        endfunction

        function void check_mean(mean_result_t got);
            mean_result_t want;
            if (pending_means.size() == 0)
            begin
                $error("unexpected result: mean_value %0d center_row %0d center_col %0d",
                       got.mean, got.tag.row, got.tag.col);
                mismatches++;
                return;
            end
            want = pending_means.pop_front();
            if (got.mean !== want.mean)
            begin
                $error("mean_value: expected %0d, got %0d", want.mean, got.mean);
                mismatches++;
            end
            if (got.tag.row !== want.tag.row)
            begin
                $error("center_row: expected %0d, got %0d", want.tag.row, got.tag.row);
                mismatches++;
            end
            if (got.tag.col !== want.tag.col)
            begin
                $error("center_col: expected %0d, got %0d", want.tag.col, got.tag.col);
                mismatches++;
            end
            if (got.tag.last !== want.tag.last)
            begin
                $error("frame_last: expected %0d, got %0d", want.tag.last, got.tag.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_ready;
    logic [CHAN_W-1:0]      red = '0;
    logic [CHAN_W-1:0]      green = '0;
    logic [CHAN_W-1:0]      blue = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [MEAN_W-1:0]      mean_value;
    logic [ROW_W-1:0]       center_row;
    logic [OCOL_W-1:0]      center_col;
    logic                   frame_last;

    mean_scoreboard sb;
    int             quiet_cycles = 0;
    drain_mode_t    drain_mode = DRAIN_FREE;
    int             drain_run = 0;

    logic [3*CHAN_W-1:0] directed_pixels [18] = '{
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
        24'hFF00FF, 24'h0180FE, 24'h000000
    };
    logic [FW_W-1:0] fixed_cols [FIXED_PHASES] = '{8'd255, 8'd4, 8'd128, 8'd2, 8'd7};
    logic [FH_W-1:0] fixed_rows [FIXED_PHASES] = '{11'd2047, 11'd5, 11'd3, 11'd0, 11'd1024};

    rgb_gray_mean3x3_filter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mean_value   (mean_value),
        .center_row   (center_row),
        .center_col   (center_col),
        .frame_last   (frame_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side stalls on its own schedule
    always @(posedge clk)
    begin
        if (drain_run == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_run  = (drain_mode == DRAIN_HOLD) ? $urandom_range(1, 40)
                                                    : $urandom_range(10, 120);
        end
        drain_run--;
        case (drain_mode)
            DRAIN_FREE:   result_ready <= 1'b1;
            DRAIN_RANDOM: result_ready <= ($urandom_range(0, 1) == 1);
            default:      result_ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a pixel taken at the same edge as a write still sees the old setting
            if (pixel_valid && pixel_ready)
                sb.note_pixel(red, green, blue);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (result_valid && result_ready)
                sb.check_mean('{mean_value, '{center_row, center_col, frame_last}});
            if ((cfg_valid && cfg_ready) || (pixel_valid && pixel_ready)
                || (result_valid && result_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("rgb_gray_mean3x3_filter_core verification failed");
                    $finish;
                end
            end
        end
    end

    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_reg(input logic [CFG_INDEX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // write back to back, drop valid after the last one
    task automatic program_frame(input logic [FW_W-1:0] cols, input logic [FH_W-1:0] rows,
                                 input logic [2:0] which);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom_range(0, 2047));
        word[FW_W-1:0] = cols;
        if ((which & WRITE_COLS) != 0)
            push_reg(REG_FRAME_WIDTH, word);
        if ((which & WRITE_ROWS) != 0)
            push_reg(REG_FRAME_HEIGHT, rows);
        if ((which & WRITE_SPARE) != 0)
            push_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        do @(posedge clk); while (!pixel_ready);
    endtask

    task automatic stream_pixels(input int unsigned count);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 40);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_pixel(pick_channel(), pick_channel(), pick_channel());
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0)
                begin
                    pixel_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        pixel_valid <= 1'b0;
    endtask

    // hold until every expected item is out, then let the pipe empty
    task automatic drain_results();
        while (sb.pending_means.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int unsigned     sent;
        int unsigned     phase;
        int unsigned     batch;
        logic [FW_W-1:0] cols;
        logic [FH_W-1:0] rows;
        logic [2:0]      which;
        sb    = new();
        sent  = 0;
        phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame: saturated pixels, then primaries and mixes
        program_frame(8'd3, 11'd3, WRITE_COLS | WRITE_ROWS | WRITE_SPARE);
        foreach (directed_pixels[i])
            send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                       directed_pixels[i][7:0]);
        pixel_valid <= 1'b0;

        // counters are never realigned, so most setting changes land mid frame
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            if (phase < FIXED_PHASES)
            begin
                cols  = fixed_cols[phase];
                rows  = fixed_rows[phase];
                which = WRITE_COLS | WRITE_ROWS;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: cols = FW_W'($urandom_range(0, 2));
                    1: cols = FW_W'($urandom_range(129, 255));
                    2: cols = FW_W'(MAX_WIDTH_DEFAULT);
                    default: cols = FW_W'($urandom_range(3, 12));
                endcase
                case ($urandom_range(0, 9))
                    0: rows = FH_W'($urandom_range(0, 2));
                    1: rows = FH_W'($urandom_range(1025, 2047));
                    2: rows = FH_W'(MAX_HEIGHT);
                    default: rows = FH_W'($urandom_range(3, 12));
                endcase
                which = 3'($urandom_range(1, 7));
            end
            program_frame(cols, rows, which);
            drain_results();
            batch = $urandom_range(40, 120) + 2 * sb.frame_cols();
            if (batch > RANDOM_ITEMS - sent)
                batch = RANDOM_ITEMS - sent;
            stream_pixels(batch);
            sent += batch;
            phase++;
        end

        while (sb.pending_means.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (sb.pending_means.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_means.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
        begin
            $display("rgb_gray_mean3x3_filter_core verification clean");
        end
        else
        begin
            $display("rgb_gray_mean3x3_filter_core verification failed");
        end
        $finish;
    end

endmodule

@@ rgb_gray_mean3x3_filter_core.f @@
rtl/rgm_pkg.sv
rtl/rgm_line_mem.sv
rtl/rgm_window.sv
rtl/rgm_out_fifo.sv
rtl/rgb_gray_mean3x3_filter_core.sv
tb/tb.sv
